FILE: design/sorted_priority_queue_core_assert.svh
//------------------------------------------------------------------------------
// Assertion macros for the sorted priority queue
// Shared helpers for concurrent checks, clocked on clk and disabled in reset.
//------------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_CORE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_CORE_ASSERT_SVH

// Same-cycle implication.
`define SPQ_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/spq_pkg.sv
//------------------------------------------------------------------------------
// Sorted priority queue package
// Operation codes, status codes, field widths and shared structs.
//------------------------------------------------------------------------------
package spq_pkg;

	localparam int DATA_W  = 32;
	localparam int COUNT_W = 5;

	typedef enum logic [1:0] {
		OP_ENQ  = 2'd0,
		OP_DEQ  = 2'd1,
		OP_PEEK = 2'd2,
		OP_TRAV = 2'd3
	} op_t;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	localparam logic CFG_ORDER_DESC    = 1'b0;
	localparam logic CFG_PRIO_FROM_VAL = 1'b1;

	// Per-cycle command broadcast to every cell of the chain.
	typedef struct packed {
		logic enq;
		logic deq;
		logic rot;
		logic desc;
	} cell_ctrl_t;

	// One result beat.
	typedef struct packed {
		logic [1:0]         status;
		logic [DATA_W-1:0]  value;
		logic [COUNT_W-1:0] count;
		logic               last;
	} result_t;

endpackage

FILE: design/spq_cell.sv
//------------------------------------------------------------------------------
// Sorted priority queue cell
// Holds one entry and decides each cycle whether to keep it, take the new
// entry, or take the entry of a neighbor or of the head cell.
//------------------------------------------------------------------------------
module spq_cell #(
	parameter int INDEX = 0,
	parameter int CNT_W = 5
) (
	input  logic                       clk,
	input  spq_pkg::cell_ctrl_t        ctrl,
	input  logic [CNT_W-1:0]           count,
	input  logic [spq_pkg::DATA_W-1:0] new_value,
	input  logic [spq_pkg::DATA_W-1:0] new_prio,
	input  logic                       lower_place,
	input  logic [spq_pkg::DATA_W-1:0] lower_value,
	input  logic [spq_pkg::DATA_W-1:0] lower_prio,
	input  logic [spq_pkg::DATA_W-1:0] upper_value,
	input  logic [spq_pkg::DATA_W-1:0] upper_prio,
	input  logic [spq_pkg::DATA_W-1:0] head_value,
	input  logic [spq_pkg::DATA_W-1:0] head_prio,
	output logic                       place,
	output logic [spq_pkg::DATA_W-1:0] value,
	output logic [spq_pkg::DATA_W-1:0] prio
);

	logic [spq_pkg::DATA_W-1:0] value_q;
	logic [spq_pkg::DATA_W-1:0] prio_q;
	logic                       occupied;
	logic                       hit;
	logic                       upper_held;

	assign occupied   = CNT_W'(INDEX) < count;
	assign upper_held = CNT_W'(INDEX + 1) < count;
	assign hit = ctrl.desc ? ($signed(new_prio) >= $signed(prio_q))
	                       : ($signed(prio_q) >= $signed(new_prio));
	// The new entry belongs at or before this cell. Once set, the flag stays
	// set toward the tail, so the first hit alone picks the insertion point
	// even when the held entries were sorted under the other order.
	assign place = lower_place || !occupied || hit;

	always_ff @(posedge clk) begin
		if (ctrl.enq) begin
			if (place && lower_place) begin
				value_q <= lower_value;
				prio_q  <= lower_prio;
			end else if (place) begin
				value_q <= new_value;
				prio_q  <= new_prio;
			end
		end else if (ctrl.deq) begin
			value_q <= upper_value;
			prio_q  <= upper_prio;
		end else if (ctrl.rot) begin
			if (upper_held) begin
				value_q <= upper_value;
				prio_q  <= upper_prio;
			end else begin
				value_q <= head_value;
				prio_q  <= head_prio;
			end
		end
	end

	assign value = value_q;
	assign prio  = prio_q;

endmodule

FILE: design/spq_out_buf.sv
//------------------------------------------------------------------------------
// Sorted priority queue output buffer
// Two-entry result queue that decouples the chain from the output stall.
//------------------------------------------------------------------------------
module spq_out_buf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  spq_pkg::result_t  push_data,
	output logic              push_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output spq_pkg::result_t  out_data
);

	spq_pkg::result_t slot0_q;
	spq_pkg::result_t slot1_q;
	logic [1:0]       fill_q;
	logic             pop;

	assign push_ready = fill_q != 2'd2;
	assign out_valid  = fill_q != 2'd0;
	assign out_data   = slot0_q;
	assign pop        = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= 2'd0;
		end else begin
			case ({push, pop})
				2'b10: fill_q <= fill_q + 2'd1;
				2'b01: fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case ({push, pop})
			2'b10: begin
				if (fill_q == 2'd0) begin
					slot0_q <= push_data;
				end else begin
					slot1_q <= push_data;
				end
			end
			2'b01: slot0_q <= slot1_q;
			2'b11: begin
				if (fill_q == 2'd1) begin
					slot0_q <= push_data;
				end else begin
					slot0_q <= slot1_q;
					slot1_q <= push_data;
				end
			end
			default: slot0_q <= slot0_q;
		endcase
	end

endmodule

FILE: design/sorted_priority_queue_core.sv
//------------------------------------------------------------------------------
// Sorted priority queue core
// Priority queue kept as a row of cells sorted head first, with enqueue,
// dequeue, peek and traverse operations.
//------------------------------------------------------------------------------
//
//  Channel   Direction  Handshake           Payload
//  s_*       in         s_tvalid/s_tready   tuser: operation; tdata: value, priority
//  m_*       out        m_tvalid/m_tready   tuser: status; tdata: value, count; tlast
//  cfg_*     in         cfg_valid/cfg_ready cfg_index, cfg_data
//
//  Enqueue, dequeue and peek act on all cells at once: every cell compares its
//  priority with the new one at the same time and shifts in one step.
//  A traverse of N entries emits N beats, one per cycle while the buffer has
//  room; the chain rotates by one cell per beat and is back in order after the last.
//  Results go through a two-beat output buffer, so a stalled output does not
//  block the next item until two beats wait.
//  Reset clears the count and the configuration; the cells need no clearing
//  because only entries below the count are ever read.
//
// Each cell holds one entry. On an enqueue a cell whose own entry lies at or
// after the insertion point takes its lower neighbor's entry, and the first
// such cell takes the new entry. A dequeue moves every entry one cell toward
// the head. The configuration port is always ready.
module sorted_priority_queue_core #(
	parameter int DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// Input beat.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // [31:0] value, [63:32] priority_req
	input  logic [1:0]  s_tuser,   // [1:0] operation
	// Result beat.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [31:0] value_out, [36:32] entry_count, rest zero
	output logic [1:0]  m_tuser,   // [1:0] status
	output logic        m_tlast,
	// Configuration writes.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic        cfg_data
);

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int DW    = spq_pkg::DATA_W;

	typedef enum logic {IDLE, TRAV} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   rem_q;
	logic               desc_q;
	logic               pfv_q;

	spq_pkg::op_t       op;
	logic [DW-1:0]      in_value;
	logic [DW-1:0]      in_prio;
	logic [DW-1:0]      new_prio;
	logic               accept;
	logic               full;
	logic               empty;

	spq_pkg::cell_ctrl_t ctrl;
	spq_pkg::result_t    push_data;
	spq_pkg::result_t    out_data;
	logic                push;
	logic                push_ready;
	logic [CNT_W-1:0]    count_d;

	logic [DW-1:0]      cell_value [DEPTH];
	logic [DW-1:0]      cell_prio  [DEPTH];
	logic               cell_place [DEPTH];

	assign op       = spq_pkg::op_t'(s_tuser);
	assign in_value = s_tdata[31:0];
	assign in_prio  = s_tdata[63:32];
	assign new_prio = pfv_q ? in_value : in_prio;
	assign full     = count_q == CNT_W'(DEPTH);
	assign empty    = count_q == '0;

	// New items wait while a traverse runs or the output buffer has no room.
	assign s_tready  = (state_q == IDLE) && push_ready;
	assign accept    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	// Command to the chain and the result beat of this cycle.
	always_comb begin
		ctrl      = '0;
		ctrl.desc = desc_q;
		push      = 1'b0;
		count_d   = count_q;
		push_data.status = spq_pkg::ST_OK;
		push_data.value  = '0;
		push_data.last   = 1'b1;
		if (state_q == TRAV) begin
			push            = push_ready;
			ctrl.rot        = push_ready;
			push_data.value = cell_value[0];
			push_data.last  = rem_q == CNT_W'(1);
		end else if (accept) begin
			push = 1'b1;
			case (op)
				spq_pkg::OP_ENQ: begin
					if (full) begin
						push_data.status = spq_pkg::ST_FULL;
					end else begin
						ctrl.enq = 1'b1;
						count_d  = count_q + CNT_W'(1);
					end
				end
				spq_pkg::OP_DEQ: begin
					if (empty) begin
						push_data.status = spq_pkg::ST_EMPTY;
					end else begin
						ctrl.deq        = 1'b1;
						count_d         = count_q - CNT_W'(1);
						push_data.value = cell_value[0];
					end
				end
				spq_pkg::OP_PEEK: begin
					if (empty) begin
						push_data.status = spq_pkg::ST_EMPTY;
					end else begin
						push_data.value = cell_value[0];
					end
				end
				spq_pkg::OP_TRAV: begin
					// A non-empty traverse emits its beats from the TRAV state.
					if (empty) begin
						push_data.status = spq_pkg::ST_EMPTY;
					end else begin
						push = 1'b0;
					end
				end
				default: push = 1'b1;
			endcase
		end
		push_data.count = spq_pkg::COUNT_W'(count_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			count_q <= '0;
			rem_q   <= '0;
			desc_q  <= 1'b0;
			pfv_q   <= 1'b0;
		end else begin
			count_q <= count_d;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					spq_pkg::CFG_ORDER_DESC:    desc_q <= cfg_data;
					spq_pkg::CFG_PRIO_FROM_VAL: pfv_q  <= cfg_data;
					default: desc_q <= desc_q;
				endcase
			end
			case (state_q)
				IDLE: begin
					if (accept && op == spq_pkg::OP_TRAV && !empty) begin
						state_q <= TRAV;
						rem_q   <= count_q;
					end
				end
				TRAV: begin
					if (push_ready) begin
						rem_q <= rem_q - CNT_W'(1);
						if (rem_q == CNT_W'(1)) begin
							state_q <= IDLE;
						end
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic          lower_place;
		logic [DW-1:0] lower_value;
		logic [DW-1:0] lower_prio;
		logic [DW-1:0] upper_value;
		logic [DW-1:0] upper_prio;
		if (i == 0) begin : g_head
			assign lower_place = 1'b0;
			assign lower_value = '0;
			assign lower_prio  = '0;
		end else begin : g_body
			assign lower_place = cell_place[i-1];
			assign lower_value = cell_value[i-1];
			assign lower_prio  = cell_prio[i-1];
		end
		if (i == DEPTH - 1) begin : g_tail
			assign upper_value = cell_value[0];
			assign upper_prio  = cell_prio[0];
		end else begin : g_inner
			assign upper_value = cell_value[i+1];
			assign upper_prio  = cell_prio[i+1];
		end
		spq_cell #(
			.INDEX (i),
			.CNT_W (CNT_W)
		) u_cell (
			.clk         (clk),
			.ctrl        (ctrl),
			.count       (count_q),
			.new_value   (in_value),
			.new_prio    (new_prio),
			.lower_place (lower_place),
			.lower_value (lower_value),
			.lower_prio  (lower_prio),
			.upper_value (upper_value),
			.upper_prio  (upper_prio),
			.head_value  (cell_value[0]),
			.head_prio   (cell_prio[0]),
			.place       (cell_place[i]),
			.value       (cell_value[i]),
			.prio        (cell_prio[i])
		);
	end

	spq_out_buf u_out_buf (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.push_ready (push_ready),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_data   (out_data)
	);

	assign m_tdata = {3'b000, out_data.count, out_data.value};
	assign m_tuser = out_data.status;
	assign m_tlast = out_data.last;

`include "sorted_priority_queue_core_assert.svh"

	`SPQ_ASSERT_IMPL(a_count_range, 1'b1, count_q <= CNT_W'(DEPTH), "count above depth")
	`SPQ_ASSERT_IMPL(a_trav_blocks, state_q == TRAV, !s_tready, "input taken during traverse")
	`SPQ_ASSERT_NEXT(a_enq_grows, accept && op == spq_pkg::OP_ENQ && !full, count_q == CNT_W'($past(count_q) + CNT_W'(1)), "enqueue did not grow count")
	`SPQ_ASSERT_NEXT(a_trav_ends, state_q == TRAV && push && push_data.last, state_q == IDLE, "traverse did not end on last beat")
	`SPQ_ASSERT_IMPL(a_trav_rem, state_q == TRAV, rem_q != '0 && rem_q <= count_q, "traverse counter out of range")

endmodule
